// File: design/ddm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddm_pkg: shared types and constants of the differential drive mixer
// Command and result words, configuration set, register indexes and the
// fixed field widths used across the pipeline.
// ----------------------------------------------------------------------------
package ddm_pkg;

  localparam int CMD_FRAC_BITS_DEF = 14;

  localparam int CMD_W      = 16;
  localparam int TOP_W      = 18;   // wheel top speed registers
  localparam int TURN_W     = 16;   // max_turn_rate and half_track
  localparam int MAG_W      = 48;   // wheel speed magnitude, 2^-(F+28) m/s units
  localparam int PROD_W     = 32;   // |steering| * max_turn_rate
  localparam int ANG_MS_W   = 25;   // |angle| * 1000
  localparam int TNUM_W     = 37;   // |angle| * 1000 * 4096
  localparam int TIME_W     = 24;
  localparam int TIME_QW    = 23;   // turn time quotient bits
  localparam int MS_PER_S   = 1000;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // issue-to-strobe distance; independent of the fraction width
  localparam int PIPE_LATENCY = 126;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_LEFT_FWD  = 3'd0,
    REG_MAX_LEFT_REV  = 3'd1,
    REG_MAX_RIGHT_FWD = 3'd2,
    REG_MAX_RIGHT_REV = 3'd3,
    REG_MAX_TURN_RATE = 3'd4,
    REG_HALF_TRACK    = 3'd5
  } cfg_reg_t;

  localparam logic [TOP_W-1:0]  RST_LEFT_TOP   = 18'd24020;
  localparam logic [TOP_W-1:0]  RST_RIGHT_TOP  = 18'd17157;
  localparam logic [TURN_W-1:0] RST_TURN_RATE  = 16'd6144;
  localparam logic [TURN_W-1:0] RST_HALF_TRACK = 16'd3932;

  typedef struct packed {
    logic                    req_type;
    logic signed [CMD_W-1:0] throttle_cmd;
    logic signed [CMD_W-1:0] steering_cmd;
    logic signed [CMD_W-1:0] turn_angle;
  } cmd_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] left_cmd;
    logic signed [CMD_W-1:0] right_cmd;
    logic [TIME_W-1:0]       turn_time_ms;
  } result_t;

  // wheel tops hold at least one; a zero write is stored as one
  typedef struct packed {
    logic [TOP_W-1:0]  left_fwd;
    logic [TOP_W-1:0]  left_rev;
    logic [TOP_W-1:0]  right_fwd;
    logic [TOP_W-1:0]  right_rev;
    logic [TURN_W-1:0] turn_rate;
    logic [TURN_W-1:0] half_track;
  } cfg_t;

  typedef struct packed {
    logic              turn;
    logic              neg_l;
    logic              neg_r;
    logic [MAG_W-1:0]  mag_l;
    logic [MAG_W-1:0]  mag_r;
    logic [TOP_W-1:0]  div_l;
    logic [TOP_W-1:0]  div_r;
    logic [PROD_W-1:0] prod;
    logic [TNUM_W-1:0] tnum;
  } front_t;

  function automatic logic [TOP_W-1:0] top_floor(input logic [TOP_W-1:0] v);
    return (v == '0) ? TOP_W'(1) : v;
  endfunction

endpackage

// File: design/ddm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddm_front: wheel speed front end
// Five register stages: operand prep, products, yaw term, wheel sums,
// magnitude and divisor select.
// ----------------------------------------------------------------------------
module ddm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ddm_pkg::cmd_t  in_cmd,
  input  ddm_pkg::cfg_t  cfg,
  output logic           out_valid,
  output ddm_pkg::front_t out_word
);
  import ddm_pkg::*;

  // stage 1
  logic                    v1, turn1;
  logic signed [CMD_W-1:0] thr1, steer1;
  logic [CMD_W-1:0]        as1, aa1;
  logic [TOP_W-1:0]        vref1;
  logic                    fwd;
  logic [TOP_W-1:0]        min_fwd, min_rev;

  // stage 2
  logic                    v2, turn2;
  logic signed [34:0]      pv2;
  logic signed [32:0]      ps2;
  logic [PROD_W-1:0]       prod2;
  logic [ANG_MS_W-1:0]     an2;

  // stage 3
  logic                    v3, turn3;
  logic signed [46:0]      vv3;
  logic signed [48:0]      w3;
  logic signed [49:0]      w_full;
  logic [PROD_W-1:0]       prod3;
  logic [TNUM_W-1:0]       tnum3;

  // stage 4
  logic                    v4, turn4;
  logic signed [49:0]      sl4, sr4;
  logic [PROD_W-1:0]       prod4;
  logic [TNUM_W-1:0]       tnum4;
  logic [49:0]             nl4, nr4;

  assign fwd     = in_cmd.req_type | ~in_cmd.throttle_cmd[CMD_W-1];
  assign min_fwd = (cfg.left_fwd < cfg.right_fwd) ? cfg.left_fwd : cfg.right_fwd;
  assign min_rev = (cfg.left_rev < cfg.right_rev) ? cfg.left_rev : cfg.right_rev;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    turn1  <= in_cmd.req_type;
    // throttle is dropped for turn requests
    thr1   <= in_cmd.req_type ? '0 : in_cmd.throttle_cmd;
    steer1 <= in_cmd.steering_cmd;
    as1    <= in_cmd.steering_cmd[CMD_W-1] ? CMD_W'(-in_cmd.steering_cmd)
                                           : CMD_W'(in_cmd.steering_cmd);
    aa1    <= in_cmd.turn_angle[CMD_W-1] ? CMD_W'(-in_cmd.turn_angle)
                                         : CMD_W'(in_cmd.turn_angle);
    vref1  <= fwd ? min_fwd : min_rev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    turn2 <= turn1;
    pv2   <= thr1 * $signed({1'b0, vref1});
    ps2   <= steer1 * $signed({1'b0, cfg.turn_rate});
    prod2 <= PROD_W'(as1) * PROD_W'(cfg.turn_rate);
    an2   <= ANG_MS_W'(aa1) * ANG_MS_W'(MS_PER_S);
  end

  assign w_full = ps2 * $signed({1'b0, cfg.half_track});

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    turn3 <= turn2;
    vv3   <= $signed({pv2, 12'b0});
    w3    <= w_full[48:0];
    prod3 <= prod2;
    tnum3 <= {an2, 12'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    turn4 <= turn3;
    sl4   <= vv3 - w3;
    sr4   <= vv3 + w3;
    prod4 <= prod3;
    tnum4 <= tnum3;
  end

  assign nl4 = -sl4;
  assign nr4 = -sr4;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v4;
    end
    out_word.turn  <= turn4;
    out_word.neg_l <= sl4[49];
    out_word.neg_r <= sr4[49];
    out_word.mag_l <= sl4[49] ? nl4[MAG_W-1:0] : sl4[MAG_W-1:0];
    out_word.mag_r <= sr4[49] ? nr4[MAG_W-1:0] : sr4[MAG_W-1:0];
    out_word.div_l <= sl4[49] ? cfg.left_rev : cfg.left_fwd;
    out_word.div_r <= sr4[49] ? cfg.right_rev : cfg.right_fwd;
    out_word.prod  <= prod4;
    out_word.tnum  <= tnum4;
  end

endmodule

// File: design/ddm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddm_div: pipelined restoring divider
// One quotient bit per stage. The starting remainder must be below the
// divisor; a sideband word travels along with each item.
// ----------------------------------------------------------------------------
module ddm_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [NW-1:0] in_low,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] low_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [DW-1:0] div_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in, d_in;
    logic [NW-1:0] l_in, q_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   trial, diff;
    logic          ge;

    if (k == 0) begin : g_head
      assign v_in = in_valid;
      assign r_in = in_rem;
      assign l_in = in_low;
      assign q_in = '0;
      assign d_in = in_div;
      assign s_in = in_side;
    end else begin : g_link
      assign v_in = vld_q[k-1];
      assign r_in = rem_q[k-1];
      assign l_in = low_q[k-1];
      assign q_in = quo_q[k-1];
      assign d_in = div_q[k-1];
      assign s_in = side_q[k-1];
    end

    assign trial = {r_in, l_in[NW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
      rem_q[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      low_q[k]  <= {l_in[NW-2:0], 1'b0};
      quo_q[k]  <= {q_in[NW-2:0], ge};
      div_q[k]  <= d_in;
      side_q[k] <= s_in;
    end
  end

  assign out_valid = vld_q[NW-1];
  assign out_quo   = quo_q[NW-1];
  assign out_side  = side_q[NW-1];

endmodule

// File: design/differential_drive_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_mixer: throttle/steering to wheel duty mixer
// Maps a throttle and steering word to left and right wheel duty words, and
// for turn requests also the time in milliseconds to rotate by an angle.
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | word
//  ----------+----------------------+------------------------------------
//  command   | start / busy         | cmd    (req_type, throttle, steer, angle)
//  result    | done (one cycle)     | result (left_cmd, right_cmd, turn_time_ms)
//  config    | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  A command word is taken on every cycle with start high and busy low; the
//  result strobes done once it has passed the whole pipeline, in issue order.
//  The latency is set by the chained one-bit-per-stage dividers: the wheel
//  ratio (48 stages), the scaling ratio (F+2), the yaw rate (44-F) and the
//  turn time (23), plus nine stages of multiply, sum and select.
//  Reset (rst, synchronous) flushes the pipeline and loads the register
//  defaults; busy stays high and cfg_ready low through the cycle after it.
//  Nothing stalls: the receiver takes every result on its strobe cycle.
// ----------------------------------------------------------------------------
module differential_drive_mixer #(
  parameter int COMMAND_FRAC_BITS = ddm_pkg::CMD_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  ddm_pkg::cmd_t                    cmd,
  output logic                             done,
  output ddm_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ddm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ddm_pkg::*;

  localparam int F         = COMMAND_FRAC_BITS;
  localparam int QW        = F + 2;                 // scaling ratio quotient bits
  localparam int RATE_FRAC = 24;                    // yaw rate fraction bits
  localparam int NUM_W     = PROD_W + RATE_FRAC;
  localparam int RATE_W    = NUM_W - F - 12;        // yaw rate and its quotient
  localparam logic [MAG_W-1:0]  ONE      = MAG_W'(1) << (F + 12);
  localparam logic [QW-1:0]     FULL     = QW'(1) << F;
  localparam logic [RATE_W-1:0] MIN_RATE = RATE_W'(16384);  // 4/4096 rad/s

  typedef struct packed {
    logic              turn;
    logic              neg_l;
    logic [PROD_W-1:0] prod;
    logic [TNUM_W-1:0] tnum;
  } s1_t;

  typedef struct packed {
    logic              turn;
    logic              scaled;
    logic              neg_l;
    logic [QW-1:0]     cu_l;
    logic [MAG_W-1:0]  m;
    logic [PROD_W-1:0] prod;
    logic [TNUM_W-1:0] tnum;
  } s2l_t;

  typedef struct packed {
    logic          neg_r;
    logic [QW-1:0] cu_r;
  } s2r_t;

  typedef struct packed {
    logic              turn;
    logic              scaled;
    logic [RATE_W-1:0] ru;
    logic [CMD_W-1:0]  lcmd;
    logic [CMD_W-1:0]  rcmd;
    logic [TNUM_W-1:0] tnum;
  } s3_t;

  typedef struct packed {
    logic             turn;
    logic             tiny;
    logic [CMD_W-1:0] lcmd;
    logic [CMD_W-1:0] rcmd;
  } s4_t;

  // Finish one wheel: pick the scaled or plain ratio, round, clamp to 1.0,
  // apply the sign and keep the low word.
  function automatic logic [CMD_W-1:0] wheel_word(input logic [QW-1:0] q,
                                                  input logic [QW-1:0] cu,
                                                  input logic          scaled,
                                                  input logic          neg);
    logic [QW:0]        qr;
    logic [QW-1:0]      c;
    logic signed [31:0] s;
    qr = {1'b0, q} + (QW+1)'(1);
    c  = scaled ? qr[QW:1] : cu;
    if (c > FULL) begin
      c = FULL;
    end
    s = neg ? -$signed(32'(c)) : $signed(32'(c));
    return s[CMD_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers and handshake
  // --------------------------------------------------------------------------
  cfg_t cfg;
  logic accept;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_fwd   <= RST_LEFT_TOP;
      cfg.left_rev   <= RST_LEFT_TOP;
      cfg.right_fwd  <= RST_RIGHT_TOP;
      cfg.right_rev  <= RST_RIGHT_TOP;
      cfg.turn_rate  <= RST_TURN_RATE;
      cfg.half_track <= RST_HALF_TRACK;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_LEFT_FWD:  cfg.left_fwd   <= top_floor(cfg_data);
        REG_MAX_LEFT_REV:  cfg.left_rev   <= top_floor(cfg_data);
        REG_MAX_RIGHT_FWD: cfg.right_fwd  <= top_floor(cfg_data);
        REG_MAX_RIGHT_REV: cfg.right_rev  <= top_floor(cfg_data);
        REG_MAX_TURN_RATE: cfg.turn_rate  <= cfg_data[TURN_W-1:0];
        REG_HALF_TRACK:    cfg.half_track <= cfg_data[TURN_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front end: wheel speeds as exact integers, magnitudes and divisors
  // --------------------------------------------------------------------------
  logic   fr_valid;
  front_t fr;

  ddm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_cmd   (cmd),
    .cfg      (cfg),
    .out_valid(fr_valid),
    .out_word (fr)
  );

  // --------------------------------------------------------------------------
  // Wheel ratio: speed magnitude over that wheel's top speed
  // --------------------------------------------------------------------------
  s1_t              s1_in, s1_out;
  logic             d1_valid, d1_neg_r;
  logic [MAG_W-1:0] lq, rq;

  assign s1_in = '{turn: fr.turn, neg_l: fr.neg_l, prod: fr.prod, tnum: fr.tnum};

  ddm_div #(.NW(MAG_W), .DW(TOP_W), .SW($bits(s1_t))) u_div_ratio_l (
    .clk(clk), .rst(rst),
    .in_valid(fr_valid), .in_rem('0), .in_low(fr.mag_l), .in_div(fr.div_l),
    .in_side(s1_in),
    .out_valid(d1_valid), .out_quo(lq), .out_side(s1_out)
  );

  ddm_div #(.NW(MAG_W), .DW(TOP_W), .SW(1)) u_div_ratio_r (
    .clk(clk), .rst(rst),
    .in_valid(fr_valid), .in_rem('0), .in_low(fr.mag_r), .in_div(fr.div_r),
    .in_side(fr.neg_r),
    .out_valid(), .out_quo(rq), .out_side(d1_neg_r)
  );

  // --------------------------------------------------------------------------
  // Larger ratio; it normalizes both wheels when it exceeds 1.0
  // --------------------------------------------------------------------------
  logic             m_valid, m_neg_r;
  logic [MAG_W-1:0] m_q, lq_q, rq_q;
  s1_t              m_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= d1_valid;
    end
    m_q     <= (lq > rq) ? lq : rq;
    lq_q    <= lq;
    rq_q    <= rq;
    m_side  <= s1_out;
    m_neg_r <= d1_neg_r;
  end

  // plain round-half-up to F fraction bits, used when no scaling applies
  logic [MAG_W:0] rnd_l, rnd_r;
  logic           scaled;
  s2l_t           s2l_in, s2l_out;
  s2r_t           s2r_in, s2r_out;
  logic           d2_valid;
  logic [QW-1:0]  ql, qr;

  assign rnd_l  = {1'b0, lq_q} + (MAG_W+1)'(2048);
  assign rnd_r  = {1'b0, rq_q} + (MAG_W+1)'(2048);
  assign scaled = (m_q > ONE);

  assign s2l_in = '{turn: m_side.turn, scaled: scaled, neg_l: m_side.neg_l,
                    cu_l: rnd_l[QW+11:12], m: m_q, prod: m_side.prod,
                    tnum: m_side.tnum};
  assign s2r_in = '{neg_r: m_neg_r, cu_r: rnd_r[QW+11:12]};

  // ratio over larger ratio with one extra bit for the rounding
  ddm_div #(.NW(QW), .DW(MAG_W), .SW($bits(s2l_t))) u_div_scale_l (
    .clk(clk), .rst(rst),
    .in_valid(m_valid), .in_rem({1'b0, lq_q[MAG_W-1:1]}),
    .in_low({lq_q[0], (QW-1)'(0)}), .in_div(m_q), .in_side(s2l_in),
    .out_valid(d2_valid), .out_quo(ql), .out_side(s2l_out)
  );

  ddm_div #(.NW(QW), .DW(MAG_W), .SW($bits(s2r_t))) u_div_scale_r (
    .clk(clk), .rst(rst),
    .in_valid(m_valid), .in_rem({1'b0, rq_q[MAG_W-1:1]}),
    .in_low({rq_q[0], (QW-1)'(0)}), .in_div(m_q), .in_side(s2r_in),
    .out_valid(), .out_quo(qr), .out_side(s2r_out)
  );

  // --------------------------------------------------------------------------
  // Wheel words are final here; the rest only serves the turn time
  // --------------------------------------------------------------------------
  logic              w_valid, w_turn, w_scaled;
  logic [CMD_W-1:0]  w_lcmd, w_rcmd;
  logic [MAG_W-1:0]  w_m;
  logic [PROD_W-1:0] w_prod;
  logic [TNUM_W-1:0] w_tnum;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else begin
      w_valid <= d2_valid;
    end
    w_lcmd   <= wheel_word(ql, s2l_out.cu_l, s2l_out.scaled, s2l_out.neg_l);
    w_rcmd   <= wheel_word(qr, s2r_out.cu_r, s2l_out.scaled, s2r_out.neg_r);
    w_turn   <= s2l_out.turn;
    w_scaled <= s2l_out.scaled;
    w_m      <= s2l_out.m;
    w_prod   <= s2l_out.prod;
    w_tnum   <= s2l_out.tnum;
  end

  // scaled yaw rate with 24 fraction bits: (prod << 24) / larger ratio;
  // the upper part of the dividend stays below the divisor when scaling
  logic [NUM_W-1:0]   num;
  logic [PROD_W+11:0] pr_sh;
  s3_t                s3_in, s3_out;
  logic               d3_valid;
  logic [RATE_W-1:0]  q_rate;

  assign num   = {w_prod, RATE_FRAC'(0)};
  assign pr_sh = {w_prod, 12'b0};
  assign s3_in = '{turn: w_turn, scaled: w_scaled, ru: RATE_W'(pr_sh >> F),
                   lcmd: w_lcmd, rcmd: w_rcmd, tnum: w_tnum};

  ddm_div #(.NW(RATE_W), .DW(MAG_W), .SW($bits(s3_t))) u_div_rate (
    .clk(clk), .rst(rst),
    .in_valid(w_valid), .in_rem(MAG_W'(num[NUM_W-1:RATE_W])),
    .in_low(num[RATE_W-1:0]), .in_div(w_m), .in_side(s3_in),
    .out_valid(d3_valid), .out_quo(q_rate), .out_side(s3_out)
  );

  // --------------------------------------------------------------------------
  // Rate select and tiny-rate check
  // --------------------------------------------------------------------------
  logic              r_valid;
  logic [RATE_W-1:0] r_rate, rate_sel;
  logic [TNUM_W-1:0] r_tnum;
  s4_t               r_side;

  assign rate_sel = s3_out.scaled ? q_rate : s3_out.ru;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= d3_valid;
    end
    r_rate <= rate_sel;
    r_tnum <= s3_out.tnum;
    r_side <= '{turn: s3_out.turn, tiny: (rate_sel < MIN_RATE),
                lcmd: s3_out.lcmd, rcmd: s3_out.rcmd};
  end

  // turn time = |angle| * 4096000 / rate; with rate at least 4/4096 rad/s
  // the quotient stays below 2^23, so the 24-bit field never overflows
  s4_t                t_side;
  logic               t_valid;
  logic [TIME_QW-1:0] q_time;

  ddm_div #(.NW(TIME_QW), .DW(RATE_W), .SW($bits(s4_t))) u_div_time (
    .clk(clk), .rst(rst),
    .in_valid(r_valid), .in_rem(RATE_W'(r_tnum[TNUM_W-1:TIME_QW])),
    .in_low(r_tnum[TIME_QW-1:0]), .in_div(r_rate), .in_side(r_side),
    .out_valid(t_valid), .out_quo(q_time), .out_side(t_side)
  );

  // --------------------------------------------------------------------------
  // Result register and strobe
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= t_valid;
    end
    result.left_cmd     <= t_side.lcmd;
    result.right_cmd    <= t_side.rcmd;
    result.turn_time_ms <= (t_side.turn && !t_side.tiny) ? TIME_W'(q_time) : '0;
  end

endmodule

// File: design/ddm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddm_port_checks: port-level checks of the mixer
// Reset flush, fixed issue-to-result distance in both directions.
// ----------------------------------------------------------------------------
module ddm_port_checks (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_ready
);
  import ddm_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!done && busy && !cfg_ready))
    else $error("pipeline not flushed by reset");

  a_word_returns: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LATENCY done)
    else $error("accepted word produced no result");

  a_result_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result without an accepted word");

endmodule

bind differential_drive_mixer ddm_port_checks u_ddm_port_checks (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .cfg_ready(cfg_ready)
);
